### src/gcd_pkg.sv
package gcd_pkg;

    localparam int CmdW = 2;
    localparam int IdW  = 16;
    localparam int WtW  = 16;
    localparam int CoefW = 16;
    localparam int DistW = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_LOAD_A  = 2'd1,
        CMD_LOAD_B  = 2'd2,
        CMD_COMPARE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ORDER   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_DISJ  = 2'd0,
        REG_WT    = 2'd1,
        REG_EXC   = 2'd2,
        REG_THRESH = 2'd3
    } reg_idx_t;

    // Queued transaction from front to back
    typedef struct packed {
        cmd_t              cmd;
        logic [IdW-1:0]    id;
        logic [WtW-1:0]    weight;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WALK_RD,
        BK_WALK,
        BK_MUL,
        BK_DIV,
        BK_SUM,
        BK_OUT
    } bk_state_t;

endpackage

### src/gcd_front.sv
module gcd_front
    import gcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic [1:0] cmd,
    input  logic [IdW-1:0] gene_id,
    input  logic signed [WtW-1:0] gene_weight,
    output job_t job,
    output logic job_valid,
    input  logic job_take
);
    // Two-entry queue
    job_t q_reg [2];
    logic rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic do_push, do_pop;

    assign full      = cnt_reg[1];
    assign job_valid = cnt_reg != 2'd0;
    assign job       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= '{cmd: cmd_t'(cmd), id: gene_id, weight: gene_weight};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

### src/gcd_divider.sv
module gcd_divider
    import gcd_pkg::*;
#(
    parameter int NumW = 64,
    parameter int DenW = 17
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [NumW-1:0] num,
    input  logic [DenW-1:0] den,
    output logic busy,
    output logic [NumW-1:0] quot
);
    localparam int CntW = $clog2(NumW + 1);
    logic [NumW-1:0] q_reg;
    logic [DenW:0]   r_reg;
    logic [CntW-1:0] cnt_reg;
    logic [DenW-1:0] d_reg;
    logic [DenW:0]   r_sh;

    assign busy = cnt_reg != '0;
    assign quot = q_reg;
    assign r_sh = {r_reg[DenW-1:0], q_reg[NumW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CntW'(NumW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_reg <= r_sh - {1'b0, d_reg};
                q_reg <= {q_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[NumW-2:0], 1'b0};
            end
        end
    end
endmodule

### src/gcd_back.sv
module gcd_back
    import gcd_pkg::*;
#(
    parameter int MAX_GENES = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  job_t job,
    input  logic job_valid,
    output logic job_take,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [DistW-1:0] cfg_data,
    output logic res_valid,
    input  logic res_take,
    output logic [DistW-1:0] res_distance,
    output logic res_same,
    output logic [1:0] res_status
);
    localparam int AW = $clog2(MAX_GENES);
    localparam int LW = $clog2(MAX_GENES + 1);
    localparam int CW = LW + 1;
    localparam int SW = WtW + 1 + LW;
    localparam int NumW = 64;
    localparam int DenW = LW + 4;

    logic [IdW-1:0] a_ids [MAX_GENES];
    logic [WtW-1:0] a_wts [MAX_GENES];
    logic [IdW-1:0] b_ids [MAX_GENES];
    logic [WtW-1:0] b_wts [MAX_GENES];

    logic [CoefW-1:0] c1_reg, c2_reg, c3_reg;
    logic [DistW-1:0] thr_reg;
    logic [LW-1:0] len_a_reg, len_b_reg;
    logic [1:0] err_reg;
    logic [IdW-1:0] last_a_reg, last_b_reg, a_first_reg, b_first_reg;

    bk_state_t state_reg, state_next;
    logic [LW-1:0] i_reg, j_reg;
    logic [IdW-1:0] ra_id_reg, rb_id_reg;
    logic [WtW-1:0] ra_w_reg, rb_w_reg;
    logic [CW-1:0] disj_reg, exc_reg;
    logic [LW-1:0] match_reg;
    logic [SW-1:0] wsum_reg;
    logic [1:0] term_reg;
    logic [NumW-1:0] acc_reg, prod_reg;
    logic div_start, div_busy;
    logic [NumW-1:0] div_num, div_quot;
    logic [DenW-1:0] div_den;
    logic [DistW-1:0] dist_reg;
    logic same_reg, out_valid_reg;
    logic [1:0] stat_reg;

    logic a_left, b_left, take_a, take_b, both, idle_take;
    logic [LW-1:0] n_len;
    logic signed [WtW:0] wdiff;
    logic [WtW:0] wabs;
    logic in_rng_a, in_rng_b;
    logic [CoefW+CW+7:0] prod_disj, prod_exc;
    logic [CoefW+SW-1:0] prod_wt;

    assign a_left = i_reg < len_a_reg;
    assign b_left = j_reg < len_b_reg;
    assign both   = a_left && b_left && ra_id_reg == rb_id_reg;
    assign take_a = !both && a_left && (!b_left || ra_id_reg < rb_id_reg);
    assign take_b = !both && !take_a && b_left;
    assign wdiff  = $signed({ra_w_reg[WtW-1], ra_w_reg}) - $signed({rb_w_reg[WtW-1], rb_w_reg});
    assign wabs   = wdiff[WtW] ? (WtW+1)'(-wdiff) : (WtW+1)'(wdiff);
    assign in_rng_a = ra_id_reg >= b_first_reg && ra_id_reg <= last_b_reg;
    assign in_rng_b = rb_id_reg >= a_first_reg && rb_id_reg <= last_a_reg;
    assign n_len  = (len_a_reg > len_b_reg) ? len_a_reg : len_b_reg;

    assign prod_disj = c1_reg * {disj_reg, 8'h00};
    assign prod_exc  = c3_reg * {exc_reg, 8'h00};
    assign prod_wt   = c2_reg * wsum_reg;

    // a waiting result only holds back the next compare
    assign idle_take = state_reg == BK_IDLE && job_valid
                       && !(out_valid_reg && job.cmd == CMD_COMPARE);
    assign job_take  = idle_take;
    assign res_valid = out_valid_reg;
    assign res_distance = dist_reg;
    assign res_same = same_reg;
    assign res_status = stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= 16'd256;
            c2_reg <= 16'd256;
            c3_reg <= 16'd256;
            thr_reg <= 32'd196608;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DISJ:   c1_reg <= cfg_data[CoefW-1:0];
                REG_WT:     c2_reg <= cfg_data[CoefW-1:0];
                REG_EXC:    c3_reg <= cfg_data[CoefW-1:0];
                REG_THRESH: thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // gene memories
    always_ff @(posedge clk)
    begin
        if (idle_take && job.cmd == CMD_LOAD_A && len_a_reg < LW'(MAX_GENES)
            && !(len_a_reg != '0 && job.id <= last_a_reg))
        begin
            a_ids[len_a_reg[AW-1:0]] <= job.id;
            a_wts[len_a_reg[AW-1:0]] <= job.weight;
        end
        if (idle_take && job.cmd == CMD_LOAD_B && len_b_reg < LW'(MAX_GENES)
            && !(len_b_reg != '0 && job.id <= last_b_reg))
        begin
            b_ids[len_b_reg[AW-1:0]] <= job.id;
            b_wts[len_b_reg[AW-1:0]] <= job.weight;
        end
        ra_id_reg <= a_ids[i_reg[AW-1:0]];
        ra_w_reg  <= a_wts[i_reg[AW-1:0]];
        rb_id_reg <= b_ids[j_reg[AW-1:0]];
        rb_w_reg  <= b_wts[j_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= '0;
            len_b_reg <= '0;
            err_reg <= ST_OK;
        end
        else if (idle_take)
        begin
            case (job.cmd)
                CMD_CLEAR:
                begin
                    len_a_reg <= '0;
                    len_b_reg <= '0;
                    err_reg <= ST_OK;
                end
                CMD_LOAD_A:
                begin
                    if (len_a_reg >= LW'(MAX_GENES))
                    begin
                        if (err_reg == ST_OK) err_reg <= ST_OVERFLOW;
                    end
                    else if (len_a_reg != '0 && job.id <= last_a_reg)
                    begin
                        if (err_reg == ST_OK) err_reg <= ST_ORDER;
                    end
                    else
                    begin
                        len_a_reg <= len_a_reg + 1'b1;
                        last_a_reg <= job.id;
                        if (len_a_reg == '0) a_first_reg <= job.id;
                    end
                end
                CMD_LOAD_B:
                begin
                    if (len_b_reg >= LW'(MAX_GENES))
                    begin
                        if (err_reg == ST_OK) err_reg <= ST_OVERFLOW;
                    end
                    else if (len_b_reg != '0 && job.id <= last_b_reg)
                    begin
                        if (err_reg == ST_OK) err_reg <= ST_ORDER;
                    end
                    else
                    begin
                        len_b_reg <= len_b_reg + 1'b1;
                        last_b_reg <= job.id;
                        if (len_b_reg == '0) b_first_reg <= job.id;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (idle_take && job.cmd == CMD_COMPARE)
                    state_next = (err_reg != ST_OK || len_a_reg == '0 || len_b_reg == '0)
                        ? BK_OUT : BK_WALK_RD;
            BK_WALK_RD: state_next = BK_WALK;
            BK_WALK:
                if (!a_left && !b_left) state_next = BK_MUL;
                else state_next = BK_WALK_RD;
            BK_MUL: state_next = BK_DIV;
            BK_DIV: if (!div_busy) state_next = BK_SUM;
            BK_SUM: state_next = (term_reg == 2'd2) ? BK_OUT : BK_MUL;
            BK_OUT: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        div_start = state_reg == BK_MUL;
        div_num = prod_reg;
        div_den = (term_reg == 2'd1) ? DenW'({match_reg, 4'b0000}) : DenW'(n_len);
    end

    gcd_divider #(.NumW(NumW), .DenW(DenW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .quot(div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_OUT) out_valid_reg <= 1'b1;
            else if (res_take) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                i_reg <= '0;
                j_reg <= '0;
                disj_reg <= '0;
                exc_reg <= '0;
                match_reg <= '0;
                wsum_reg <= '0;
                term_reg <= 2'd0;
                acc_reg <= '0;
                if (idle_take && job.cmd == CMD_COMPARE)
                    stat_reg <= (err_reg != ST_OK) ? err_reg :
                                (len_a_reg == '0 || len_b_reg == '0) ? ST_EMPTY : ST_OK;
            end
            BK_WALK:
            begin
                if (both)
                begin
                    wsum_reg <= wsum_reg + SW'(wabs);
                    match_reg <= match_reg + 1'b1;
                    i_reg <= i_reg + 1'b1;
                    j_reg <= j_reg + 1'b1;
                end
                else if (take_a)
                begin
                    if (in_rng_a) disj_reg <= disj_reg + 1'b1;
                    else exc_reg <= exc_reg + 1'b1;
                    i_reg <= i_reg + 1'b1;
                end
                else if (take_b)
                begin
                    if (in_rng_b) disj_reg <= disj_reg + 1'b1;
                    else exc_reg <= exc_reg + 1'b1;
                    j_reg <= j_reg + 1'b1;
                end
                // precompute first product
                prod_reg <= NumW'(prod_disj);
            end
            BK_WALK_RD: ;
            BK_MUL: ;
            BK_DIV: ;
            BK_SUM:
            begin
                if (!(term_reg == 2'd1 && match_reg == '0))
                    acc_reg <= acc_reg + div_quot;
                term_reg <= term_reg + 1'b1;
                if (term_reg == 2'd0)
                    prod_reg <= NumW'(prod_wt);
                else
                    prod_reg <= NumW'(prod_exc);
            end
            BK_OUT:
            begin
                if (stat_reg != ST_OK)
                begin
                    dist_reg <= '0;
                    same_reg <= 1'b0;
                end
                else if (acc_reg > NumW'(32'hFFFF_FFFF))
                begin
                    dist_reg <= 32'hFFFF_FFFF;
                    same_reg <= 1'b0;
                    stat_reg <= ST_OVERFLOW;
                end
                else
                begin
                    dist_reg <= acc_reg[DistW-1:0];
                    same_reg <= acc_reg[DistW-1:0] < thr_reg;
                end
            end
            default: ;
        endcase
    end
endmodule

### src/genome_compatibility_distance.sv
// Load and clear: queued, then applied when the back end takes them, one per cycle
// while the back end is idle. Compare: the back end walks both lists in merge steps
// (at most len_a+len_b), each a read and a walk state, plus one closing step, then
// three multiply and serial divide passes and an output state; a load error or an
// empty list goes straight to output. A waiting result holds only the next compare.
// Reset clears lengths, load error, queue and result; coefficients return to defaults.
module genome_compatibility_distance
    import gcd_pkg::*;
#(
    parameter int MAX_GENES = 256
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic [1:0] cmd,
    input  logic [IdW-1:0] gene_id,
    input  logic signed [WtW-1:0] gene_weight,
    output logic empty,
    input  logic pop,
    output logic [DistW-1:0] distance,
    output logic same_species,
    output logic [1:0] status,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [DistW-1:0] cfg_data
);
    job_t job;
    logic job_valid, job_take, res_valid;

    gcd_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .gene_id(gene_id), .gene_weight(gene_weight), .job(job),
        .job_valid(job_valid), .job_take(job_take)
    );

    gcd_back #(.MAX_GENES(MAX_GENES)) u_back (
        .clk(clk), .rst_n(rst_n), .job(job), .job_valid(job_valid),
        .job_take(job_take), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .res_valid(res_valid), .res_take(pop),
        .res_distance(distance), .res_same(same_species), .res_status(status)
    );

    assign empty = !res_valid;
endmodule

### src/gcd_checker.sv
module gcd_checker
    import gcd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input logic [DistW-1:0] distance,
    input logic same_species,
    input logic [1:0] status
);
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status != ST_OK && status != ST_OVERFLOW |-> distance == '0)
        else $error("error result with nonzero distance");
    a_same_ok: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && same_species |-> status == ST_OK)
        else $error("same species with bad status");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status == ST_OVERFLOW && distance != '0 |-> distance == 32'hFFFF_FFFF)
        else $error("overflow not saturated");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(distance))
        else $error("result dropped");
endmodule

bind genome_compatibility_distance gcd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .distance(distance),
    .same_species(same_species), .status(status)
);
